// File: sv/cdad_pkg.sv
// ============================================================================
// cdad_pkg
// Shared types, constants and the month-length lookup for the date adder.
// ============================================================================
package cdad_pkg;

    // Field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned OFF_W   = 17;
    localparam int unsigned STAT_W  = 2;
    // Working day count: day plus offset, one extra bit of headroom
    localparam int unsigned ACC_W   = OFF_W + 1;
    // Century count and year-within-century
    localparam int unsigned CENT_W  = 8;
    localparam int unsigned REM_W   = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd0;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;
    localparam logic [REM_W-1:0]   REM_LAST  = 7'd99;

    // Reciprocal of 100: floor(y / 100) == (y * 5243) >> 19 for all 14-bit y
    localparam int unsigned        RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int unsigned        RECIP_SHIFT = 19;
    localparam int unsigned        PROD_W      = YEAR_W + RECIP_W;

    // Days in each month, common year; entry 0 is unused
    localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new item
        logic prep;   // form year-within-century and the working day count
        logic check;  // validate the input date
        logic step;   // move one month forward or backward
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic date_bad;  // input date is not a valid date
        logic step_end;  // day count settled, or year ran out of range
    } t_dp_sts;

    // Length of a month; zero for a month code outside January to December
    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        if (month == 4'd0 || month > MONTH_DEC) begin
            len = 5'd0;
        end else if (month == MONTH_FEB && leap) begin
            len = FEB_LEAP_DAYS;
        end else begin
            len = MONTH_LEN[month];
        end
        return len;
    endfunction

endpackage

// File: sv/calendar_date_add_days.sv
// ============================================================================
// calendar_date_add_days
// Adds a signed day offset to a Gregorian date, one month per clock cycle.
// ============================================================================
// An item is taken when start is high and busy is low. The result is shown for
// exactly one cycle with o_done high and cannot be held off, so capture it
// then. After the load the controller prepares the working day count, checks
// the input date, then steps the date one month per cycle, for about 2155
// months at most over the full offset range, before it shows the result. An
// invalid input date skips the stepping and finishes with status 1; a result
// year outside 0 to 9999 gives status 2. In both cases the input date is
// returned unchanged. busy stays high from acceptance through the result cycle.
module calendar_date_add_days
    import cdad_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [YEAR_W-1:0]       i_start_year,
    input  logic [MONTH_W-1:0]      i_start_month,
    input  logic [DAY_W-1:0]        i_start_day,
    input  logic signed [OFF_W-1:0] i_day_offset,
    output logic                    o_done,
    output logic [YEAR_W-1:0]       o_result_year,
    output logic [MONTH_W-1:0]      o_result_month,
    output logic [DAY_W-1:0]        o_result_day,
    output logic [STAT_W-1:0]       o_status
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence the item
    cdad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // Hold and step the date
    cdad_datapath u_datapath (
        .i_clk          (i_clk),
        .i_start_year   (i_start_year),
        .i_start_month  (i_start_month),
        .i_start_day    (i_start_day),
        .i_day_offset   (i_day_offset),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result_year  (o_result_year),
        .o_result_month (o_result_month),
        .o_result_day   (o_result_day),
        .o_status       (o_status)
    );

endmodule

// File: sv/cdad_datapath.sv
// ============================================================================
// cdad_datapath
// Date registers, leap-year tracking and the one-month-per-cycle stepper.
// ============================================================================
module cdad_datapath
    import cdad_pkg::*;
(
    input  logic                 i_clk,
    input  logic [YEAR_W-1:0]    i_start_year,
    input  logic [MONTH_W-1:0]   i_start_month,
    input  logic [DAY_W-1:0]     i_start_day,
    input  logic signed [OFF_W-1:0] i_day_offset,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [YEAR_W-1:0]    o_result_year,
    output logic [MONTH_W-1:0]   o_result_month,
    output logic [DAY_W-1:0]     o_result_day,
    output logic [STAT_W-1:0]    o_status
);

    // Captured item
    logic [YEAR_W-1:0]        r_in_year;
    logic [MONTH_W-1:0]       r_in_month;
    logic [DAY_W-1:0]         r_in_day;
    logic signed [OFF_W-1:0]  r_off;

    // Working date
    logic [YEAR_W-1:0]        r_year,  n_year;
    logic [MONTH_W-1:0]       r_month, n_month;
    logic signed [ACC_W-1:0]  r_day,   n_day;
    logic [CENT_W-1:0]        r_quot,  n_quot;
    logic [REM_W-1:0]         r_rem,   n_rem;
    t_status                  r_status, n_status;

    logic [PROD_W-1:0]        w_prod;
    logic [YEAR_W-1:0]        w_cent_years;
    logic                     w_leap;
    logic [DAY_W-1:0]         w_dim_cur;
    logic [DAY_W-1:0]         w_dim_prev;
    logic [DAY_W-1:0]         w_dim_in;
    logic                     w_fwd;
    logic                     w_bwd;
    logic                     w_top_wrap;
    logic                     w_bot_wrap;
    logic                     w_bad;

    // Century of the incoming year by reciprocal multiply
    assign w_prod = PROD_W'(i_start_year) * PROD_W'(RECIP_100);

    // quot * 100 as shifts and adds
    assign w_cent_years = YEAR_W'({r_quot, 6'b0}) + YEAR_W'({r_quot, 5'b0})
                        + YEAR_W'({r_quot, 2'b0});

    // Leap: divisible by 4, and either not a century or a multiple of 400
    assign w_leap = (r_year[1:0] == 2'b00) && ((r_rem != '0) || (r_quot[1:0] == 2'b00));

    assign w_dim_cur  = month_days(r_month, w_leap);
    assign w_dim_prev = month_days(r_month - 4'd1, w_leap);
    assign w_dim_in   = month_days(r_in_month, w_leap);

    // Step direction
    assign w_fwd = r_day > $signed({{(ACC_W-DAY_W){1'b0}}, w_dim_cur});
    assign w_bwd = r_day[ACC_W-1] || (r_day == '0);

    assign w_top_wrap = w_fwd && (r_month == MONTH_DEC) && (r_year == YEAR_MAX);
    assign w_bot_wrap = !w_fwd && w_bwd && (r_month == MONTH_JAN) && (r_year == YEAR_MIN);

    // Input date validation
    assign w_bad = (r_in_year > YEAR_MAX) || (r_in_month == 4'd0) || (r_in_month > MONTH_DEC)
                || (r_in_day == 5'd0) || (r_in_day > w_dim_in);

    assign o_sts.date_bad = w_bad;
    assign o_sts.step_end = !(w_fwd || w_bwd) || w_top_wrap || w_bot_wrap;

    // Next-state logic for the working registers
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_status = r_status;
        if (i_cmd.load) begin
            n_year   = i_start_year;
            n_month  = i_start_month;
            n_quot   = w_prod[RECIP_SHIFT +: CENT_W];
            n_status = ST_OK;
        end else if (i_cmd.prep) begin
            n_rem = REM_W'(r_year - w_cent_years);
            n_day = $signed({{(ACC_W-DAY_W){1'b0}}, r_in_day}) + ACC_W'(r_off);
        end else if (i_cmd.check) begin
            if (w_bad) begin
                n_status = ST_BAD_DATE;
            end
        end else if (i_cmd.step) begin
            if (w_top_wrap || w_bot_wrap) begin
                n_status = ST_RANGE;
            end else if (w_fwd) begin
                // Advance one month
                n_day = r_day - $signed({{(ACC_W-DAY_W){1'b0}}, w_dim_cur});
                if (r_month == MONTH_DEC) begin
                    n_month = MONTH_JAN;
                    n_year  = r_year + 14'd1;
                    if (r_rem == REM_LAST) begin
                        n_rem  = '0;
                        n_quot = r_quot + 8'd1;
                    end else begin
                        n_rem = r_rem + 7'd1;
                    end
                end else begin
                    n_month = r_month + 4'd1;
                end
            end else if (w_bwd) begin
                // Step back one month and add its length
                if (r_month == MONTH_JAN) begin
                    n_month = MONTH_DEC;
                    n_year  = r_year - 14'd1;
                    n_day   = r_day + $signed({{(ACC_W-DAY_W){1'b0}}, MONTH_LEN[MONTH_DEC]});
                    if (r_rem == '0) begin
                        n_rem  = REM_LAST;
                        n_quot = r_quot - 8'd1;
                    end else begin
                        n_rem = r_rem - 7'd1;
                    end
                end else begin
                    n_month = r_month - 4'd1;
                    n_day   = r_day + $signed({{(ACC_W-DAY_W){1'b0}}, w_dim_prev});
                end
            end
        end
    end

    // Hold the captured item and the working date
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_year  <= i_start_year;
            r_in_month <= i_start_month;
            r_in_day   <= i_start_day;
            r_off      <= i_day_offset;
        end
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_status <= n_status;
    end

    // Echo the input date on any error
    always_comb begin
        if (r_status != ST_OK) begin
            o_result_year  = r_in_year;
            o_result_month = r_in_month;
            o_result_day   = r_in_day;
        end else begin
            o_result_year  = r_year;
            o_result_month = r_month;
            o_result_day   = r_day[DAY_W-1:0];
        end
    end
    assign o_status = r_status;

endmodule

// File: sv/cdad_ctrl.sv
// ============================================================================
// cdad_ctrl
// Controller: sequences load, preparation, check, month stepping and result.
// ============================================================================
module cdad_ctrl
    import cdad_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_CHECK = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.date_bad ? S_DONE : S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
